/* rtl/frwl_pkg.sv */
// Shared types, codes and default sizes of the fair reader-writer lock unit.
package frwl_pkg;

  localparam int unsigned QUEUE_DEPTH_DEF = 16;
  localparam int unsigned MAX_READERS_DEF = 255;
  localparam int unsigned ID_BITS_DEF     = 8;

  typedef enum logic [1:0] {
    OP_READ_LOCK    = 2'd0,
    OP_WRITE_LOCK   = 2'd1,
    OP_READ_UNLOCK  = 2'd2,
    OP_WRITE_UNLOCK = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    EV_GRANT      = 3'd0,
    EV_QUEUED     = 3'd1,
    EV_RELEASED   = 3'd2,
    EV_WOKEN      = 3'd3,
    EV_FULL       = 3'd4,
    EV_BAD_UNLOCK = 3'd5,
    EV_SATURATED  = 3'd6
  } ev_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_WAKE = 1'b1
  } st_e;

  typedef struct packed {
    logic push;
    logic pop;
  } queue_ctrl_t;

endpackage

/* rtl/frwl_cell.sv */
// One cell of the wait queue chain: holds one entry and takes its neighbor's on a shift.
module frwl_cell #(
  parameter int unsigned WIDTH = 9
) (
  input  logic             clk_i,
  input  logic             load_i,
  input  logic             shift_i,
  input  logic [WIDTH-1:0] load_data_i,
  input  logic [WIDTH-1:0] next_data_i,
  output logic [WIDTH-1:0] data_o
);

  logic [WIDTH-1:0] data_q;

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= load_data_i;
    end else if (shift_i) begin
      data_q <= next_data_i;
    end
  end

  assign data_o = data_q;

endmodule

/* rtl/frwl_queue.sv */
// Wait queue built as a chain of cells; the head sits in cell zero and a pop shifts the chain.
module frwl_queue import frwl_pkg::*; #(
  parameter int unsigned DEPTH = QUEUE_DEPTH_DEF,
  parameter int unsigned WIDTH = ID_BITS_DEF + 1,
  parameter int unsigned CNT_W = $clog2(DEPTH + 1)
) (
  input  logic             clk_i,
  input  queue_ctrl_t      ctrl_i,
  input  logic [CNT_W-1:0] wr_idx_i,
  input  logic [WIDTH-1:0] wr_data_i,
  output logic [WIDTH-1:0] head_o,
  output logic [WIDTH-1:0] next_o
);

  logic [WIDTH-1:0] data [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [WIDTH-1:0] nb;
    if (i < DEPTH - 1) begin : g_mid
      assign nb = data[i+1];
    end else begin : g_end
      assign nb = data[i];
    end
    frwl_cell #(
      .WIDTH(WIDTH)
    ) u_cell (
      .clk_i      (clk_i),
      .load_i     (ctrl_i.push && (wr_idx_i == CNT_W'(i))),
      .shift_i    (ctrl_i.pop),
      .load_data_i(wr_data_i),
      .next_data_i(nb),
      .data_o     (data[i])
    );
  end

  assign head_o = data[0];
  assign next_o = data[1];

endmodule

/* rtl/fair_reader_writer_lock_unit.sv */
// Top level of the fair reader-writer lock unit with its control and result register.
// Each request transaction is taken and answered by results in the output register; a lock
// request, a refused request or an unlock that wakes nobody gives one result. An unlock
// that wakes N waiters gives 1 + N results, one woken grant per cycle while the result
// register is free or being emptied, because the waiting requests leave the head of the
// cell chain one shift at a time. A new request is taken only after the last result of the
// previous one has been produced, and while the result register is free or being emptied.
module fair_reader_writer_lock_unit import frwl_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int unsigned MAX_READERS = MAX_READERS_DEF,
  parameter int unsigned ID_BITS     = ID_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] opcode_i,
  input  logic [7:0] requester_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [2:0] event_res_o,
  output logic [7:0] agent_o,
  output logic       grant_is_write_o,
  output logic [7:0] active_readers_o,
  output logic       writer_held_o,
  output logic [4:0] waiting_o,
  output logic       last_o
);

  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned RD_W  = $clog2(MAX_READERS + 1);
  localparam int unsigned ENT_W = ID_BITS + 1;

  st_e              state_q, state_d;
  logic [RD_W-1:0]  reader_q, reader_d;
  logic             writer_q, writer_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             out_valid_q, out_valid_d;

  ev_e              ev_q, ev_d;
  logic [7:0]       agent_q, agent_d;
  logic             isw_q, isw_d;
  logic [7:0]       act_q, act_d;
  logic             wr_held_q, wr_held_d;
  logic [4:0]       wait_q, wait_d;
  logic             last_q, last_d;

  queue_ctrl_t      q_ctrl;
  logic [ENT_W-1:0] push_entry;
  logic [ENT_W-1:0] head;
  logic [ENT_W-1:0] nxt;

  logic             slot_free;
  logic             in_fire;
  logic             emit;
  logic             wake;
  logic             more;
  logic             q_empty;
  logic             q_full;
  logic             rc_max;
  logic [RD_W-1:0]  rc_inc;

  frwl_queue #(
    .DEPTH(QUEUE_DEPTH),
    .WIDTH(ENT_W),
    .CNT_W(CNT_W)
  ) u_queue (
    .clk_i    (clk_i),
    .ctrl_i   (q_ctrl),
    .wr_idx_i (count_q),
    .wr_data_i(push_entry),
    .head_o   (head),
    .next_o   (nxt)
  );

  assign slot_free = !out_valid_q || out_ready_i;
  assign in_fire   = in_valid_i && in_ready_o;
  assign q_empty   = (count_q == '0);
  assign q_full    = (count_q == CNT_W'(QUEUE_DEPTH));
  assign rc_max    = (reader_q == RD_W'(MAX_READERS));
  assign rc_inc    = reader_q + RD_W'(1);
  assign more      = (count_q > CNT_W'(1)) && !nxt[ID_BITS] &&
                     (rc_inc != RD_W'(MAX_READERS));

  always_comb begin
    in_ready_o = (state_q == ST_IDLE) && slot_free;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire && wake) begin
          state_d = ST_WAKE;
        end
      end
      ST_WAKE: begin
        if (slot_free && (head[ID_BITS] || !more)) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    reader_d   = reader_q;
    writer_d   = writer_q;
    count_d    = count_q;
    q_ctrl     = '0;
    push_entry = {1'b0, ID_BITS'(requester_i)};
    emit       = 1'b0;
    wake       = 1'b0;
    ev_d       = ev_q;
    agent_d    = agent_q;
    isw_d      = isw_q;
    last_d     = last_q;
    if (in_fire) begin
      emit    = 1'b1;
      agent_d = requester_i;
      last_d  = 1'b1;
      case (op_e'(opcode_i))
        OP_READ_LOCK: begin
          isw_d = 1'b0;
          if (!writer_q && q_empty) begin
            if (rc_max) begin
              ev_d = EV_SATURATED;
            end else begin
              reader_d = rc_inc;
              ev_d     = EV_GRANT;
            end
          end else if (q_full) begin
            ev_d = EV_FULL;
          end else begin
            q_ctrl.push = 1'b1;
            count_d     = count_q + CNT_W'(1);
            ev_d        = EV_QUEUED;
          end
        end
        OP_WRITE_LOCK: begin
          isw_d      = 1'b1;
          push_entry = {1'b1, ID_BITS'(requester_i)};
          if (!writer_q && q_empty && (reader_q == '0)) begin
            writer_d = 1'b1;
            ev_d     = EV_GRANT;
          end else if (q_full) begin
            ev_d = EV_FULL;
          end else begin
            q_ctrl.push = 1'b1;
            count_d     = count_q + CNT_W'(1);
            ev_d        = EV_QUEUED;
          end
        end
        OP_READ_UNLOCK: begin
          isw_d = 1'b0;
          if (reader_q == '0) begin
            ev_d = EV_BAD_UNLOCK;
          end else begin
            reader_d = reader_q - RD_W'(1);
            ev_d     = EV_RELEASED;
            if ((reader_q == RD_W'(1)) && !q_empty) begin
              wake   = 1'b1;
              last_d = 1'b0;
            end
          end
        end
        OP_WRITE_UNLOCK: begin
          isw_d = 1'b1;
          if (!writer_q) begin
            ev_d = EV_BAD_UNLOCK;
          end else begin
            writer_d = 1'b0;
            ev_d     = EV_RELEASED;
            if (!q_empty && (head[ID_BITS] || !rc_max)) begin
              wake   = 1'b1;
              last_d = 1'b0;
            end
          end
        end
        default: ;
      endcase
    end else if ((state_q == ST_WAKE) && slot_free) begin
      emit       = 1'b1;
      q_ctrl.pop = 1'b1;
      count_d    = count_q - CNT_W'(1);
      agent_d    = 8'(head[ID_BITS-1:0]);
      ev_d       = EV_WOKEN;
      if (head[ID_BITS]) begin
        writer_d = 1'b1;
        isw_d    = 1'b1;
        last_d   = 1'b1;
      end else begin
        reader_d = rc_inc;
        isw_d    = 1'b0;
        last_d   = !more;
      end
    end
    act_d     = 8'(reader_d);
    wr_held_d = writer_d;
    wait_d    = 5'(count_d);
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      reader_q    <= '0;
      writer_q    <= 1'b0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      reader_q    <= reader_d;
      writer_q    <= writer_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      ev_q      <= ev_d;
      agent_q   <= agent_d;
      isw_q     <= isw_d;
      act_q     <= act_d;
      wr_held_q <= wr_held_d;
      wait_q    <= wait_d;
      last_q    <= last_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign event_res_o      = ev_q;
  assign agent_o          = agent_q;
  assign grant_is_write_o = isw_q;
  assign active_readers_o = act_q;
  assign writer_held_o    = wr_held_q;
  assign waiting_o        = wait_q;
  assign last_o           = last_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni) writer_q |-> (reader_q == '0))
    else $error("A writer holds the lock while readers are active.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(QUEUE_DEPTH))
    else $error("The wait queue count exceeds the queue depth.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WAKE) |-> !q_empty)
    else $error("The wake sequence runs with an empty queue.");

  assert property (@(posedge clk_i) disable iff (!rst_ni) in_fire |=> out_valid_o)
    else $error("An accepted request produced no result.");

endmodule

/* sim/lock_checker.sv */
`timescale 1ns / 1ps
// Scoreboard for the reader-writer lock unit: predicts each result transaction and compares it.
module lock_checker import frwl_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int unsigned MAX_READERS = MAX_READERS_DEF,
  parameter int unsigned ID_BITS     = ID_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_ready_i,
  input  logic [1:0] opcode_i,
  input  logic [7:0] requester_i,
  input  logic       out_valid_i,
  input  logic       out_ready_i,
  input  logic [2:0] event_res_i,
  input  logic [7:0] agent_i,
  input  logic       grant_is_write_i,
  input  logic [7:0] active_readers_i,
  input  logic       writer_held_i,
  input  logic [4:0] waiting_i,
  input  logic       last_i,
  output int         mismatches_o,
  output int         outstanding_o,
  output int         requests_o,
  output int         results_o
);

  localparam logic [7:0] ID_MASK = 8'((32'd1 << ID_BITS) - 32'd1);

  typedef struct packed {
    logic       is_write;
    logic [7:0] id;
  } waiter_t;

  typedef struct packed {
    ev_e        ev;
    logic [7:0] agent;
    logic       is_write;
    logic [7:0] readers;
    logic       writer;
    logic [4:0] waiting;
    logic       last;
  } lock_result_t;

  int unsigned  held_readers = 0;
  logic         writer_held = 1'b0;
  waiter_t      wait_line[$];
  lock_result_t expected_results[$];
  lock_result_t want;
  int           errors = 0;
  int           requests = 0;
  int           results = 0;

  function automatic void note_result(ev_e ev, logic [7:0] who, logic is_write);
    lock_result_t r;
    r.ev       = ev;
    r.agent    = who;
    r.is_write = is_write;
    r.readers  = held_readers[7:0];
    r.writer   = writer_held;
    r.waiting  = 5'(wait_line.size());
    r.last     = 1'b0;
    expected_results.push_back(r);
  endfunction

  function automatic void wake_waiters();
    bit      readers_woken;
    waiter_t head;
    readers_woken = 1'b0;
    while (wait_line.size() != 0) begin
      head = wait_line[0];
      if (head.is_write) begin
        if (!readers_woken) begin
          void'(wait_line.pop_front());
          writer_held = 1'b1;
          note_result(EV_WOKEN, head.id, 1'b1);
        end
        break;
      end
      if (held_readers >= MAX_READERS) break;
      void'(wait_line.pop_front());
      held_readers++;
      readers_woken = 1'b1;
      note_result(EV_WOKEN, head.id, 1'b0);
    end
  endfunction

  function automatic void enqueue_or_refuse(logic [7:0] who, logic is_write);
    waiter_t entry;
    if (wait_line.size() >= QUEUE_DEPTH) begin
      note_result(EV_FULL, who, is_write);
    end else begin
      entry.is_write = is_write;
      entry.id       = who & ID_MASK;
      wait_line.push_back(entry);
      note_result(EV_QUEUED, who, is_write);
    end
  endfunction

  function automatic void predict_results(logic [1:0] op, logic [7:0] who);
    lock_result_t tail;
    case (op)
      OP_READ_LOCK: begin
        if (!writer_held && wait_line.size() == 0) begin
          if (held_readers >= MAX_READERS) begin
            note_result(EV_SATURATED, who, 1'b0);
          end else begin
            held_readers++;
            note_result(EV_GRANT, who, 1'b0);
          end
        end else begin
          enqueue_or_refuse(who, 1'b0);
        end
      end
      OP_WRITE_LOCK: begin
        if (!writer_held && wait_line.size() == 0 && held_readers == 0) begin
          writer_held = 1'b1;
          note_result(EV_GRANT, who, 1'b1);
        end else begin
          enqueue_or_refuse(who, 1'b1);
        end
      end
      OP_READ_UNLOCK: begin
        if (held_readers == 0) begin
          note_result(EV_BAD_UNLOCK, who, 1'b0);
        end else begin
          held_readers--;
          note_result(EV_RELEASED, who, 1'b0);
          if (held_readers == 0) wake_waiters();
        end
      end
      default: begin
        if (!writer_held) begin
          note_result(EV_BAD_UNLOCK, who, 1'b1);
        end else begin
          writer_held = 1'b0;
          note_result(EV_RELEASED, who, 1'b1);
          wake_waiters();
        end
      end
    endcase
    tail = expected_results.pop_back();
    tail.last = 1'b1;
    expected_results.push_back(tail);
  endfunction

  function automatic int field_mismatch(string name, logic [7:0] expected, logic [7:0] actual);
    if (actual !== expected) begin
      $error("%s: expected %0d, got %0d", name, expected, actual);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_readers = 0;
      writer_held = 1'b0;
      wait_line.delete();
      expected_results.delete();
      outstanding_o <= 0;
      mismatches_o <= errors;
      requests_o <= 0;
      results_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        results++;
        if (expected_results.size() == 0) begin
          $error("Result transaction with none expected: event_res %0d, agent %0d",
                 event_res_i, agent_i);
          errors++;
        end else begin
          want = expected_results.pop_front();
          errors += field_mismatch("event_res", 8'(want.ev), 8'(event_res_i));
          errors += field_mismatch("agent", want.agent, agent_i);
          errors += field_mismatch("grant_is_write", 8'(want.is_write), 8'(grant_is_write_i));
          errors += field_mismatch("active_readers", want.readers, active_readers_i);
          errors += field_mismatch("writer_held", 8'(want.writer), 8'(writer_held_i));
          errors += field_mismatch("waiting", 8'(want.waiting), 8'(waiting_i));
          errors += field_mismatch("last", 8'(want.last), 8'(last_i));
        end
      end
      if (in_valid_i && in_ready_i) begin
        requests++;
        predict_results(opcode_i, requester_i);
      end
      outstanding_o <= expected_results.size();
      mismatches_o <= errors;
      requests_o <= requests;
      results_o <= results;
    end
  end

endmodule

/* sim/testbench.sv */
`timescale 1ns / 1ps
// Top of the lock unit testbench: clock, reset, request stimulus, result sink and verdict.
module testbench;
  import frwl_pkg::*;

  localparam int QUIET_LIMIT  = 2000;
  localparam int RANDOM_ITEMS = 70;
  localparam int TAIL_CYCLES  = 20;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic [1:0] opcode = OP_READ_LOCK;
  logic [7:0] requester = 8'd0;
  logic       out_ready = 1'b0;
  logic       in_ready;
  logic       out_valid;
  logic [2:0] event_res;
  logic [7:0] agent;
  logic       grant_is_write;
  logic [7:0] active_readers;
  logic       writer_held;
  logic [4:0] waiting;
  logic       result_last;

  bit         calm = 1'b0;
  logic [1:0] stall_left = 2'd0;
  int         quiet_cycles = 0;
  int         mismatches;
  int         outstanding;
  int         requests;
  int         results;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  fair_reader_writer_lock_unit dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready),
    .opcode_i         (opcode),
    .requester_i      (requester),
    .out_valid_o      (out_valid),
    .out_ready_i      (out_ready),
    .event_res_o      (event_res),
    .agent_o          (agent),
    .grant_is_write_o (grant_is_write),
    .active_readers_o (active_readers),
    .writer_held_o    (writer_held),
    .waiting_o        (waiting),
    .last_o           (result_last)
  );

  lock_checker u_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_ready_i       (in_ready),
    .opcode_i         (opcode),
    .requester_i      (requester),
    .out_valid_i      (out_valid),
    .out_ready_i      (out_ready),
    .event_res_i      (event_res),
    .agent_i          (agent),
    .grant_is_write_i (grant_is_write),
    .active_readers_i (active_readers),
    .writer_held_i    (writer_held),
    .waiting_i        (waiting),
    .last_i           (result_last),
    .mismatches_o     (mismatches),
    .outstanding_o    (outstanding),
    .requests_o       (requests),
    .results_o        (results)
  );

  always @(posedge clk) begin : result_sink
    int draw;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (out_valid && out_ready) begin
      draw = calm ? 0 : $urandom_range(0, 3);
      stall_left <= 2'(draw);
      out_ready <= (draw == 0);
    end else if (stall_left != 2'd0) begin
      stall_left <= stall_left - 2'd1;
      out_ready <= (stall_left == 2'd1);
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Timeout: no transaction for %0d cycles", QUIET_LIMIT);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic send_request(op_e op, logic [7:0] who);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    opcode <= op;
    requester <= who;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic wait_all_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  initial begin
    int   picked;
    int   burst_len;
    int   mode;
    int   sent_random;
    int   t_read_lock;
    int   t_write_lock;
    int   t_read_unlock;
    op_e  op;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_request(OP_READ_UNLOCK, 8'h00);
    send_request(OP_WRITE_UNLOCK, 8'hFF);
    send_request(OP_READ_LOCK, 8'h00);
    send_request(OP_READ_LOCK, 8'hFF);
    send_request(OP_WRITE_LOCK, 8'h5A);
    send_request(OP_READ_LOCK, 8'hA5);
    send_request(OP_READ_UNLOCK, 8'h00);
    send_request(OP_READ_UNLOCK, 8'hFF);
    send_request(OP_WRITE_UNLOCK, 8'h5A);
    send_request(OP_READ_UNLOCK, 8'hA5);
    send_request(OP_WRITE_LOCK, 8'h11);
    for (int i = 0; i < 16; i++) begin
      send_request((i == 3 || i == 9) ? OP_WRITE_LOCK : OP_READ_LOCK, 8'(8'h80 + i));
    end
    send_request(OP_WRITE_LOCK, 8'h7F);
    send_request(OP_READ_LOCK, 8'hFE);
    send_request(OP_WRITE_UNLOCK, 8'h11);
    wait_all_results();

    sent_random = 0;
    while (sent_random < RANDOM_ITEMS) begin
      mode = $urandom_range(0, 2);
      calm = ($urandom_range(0, 3) == 0);
      burst_len = $urandom_range(4, 12);
      case (mode)
        0: begin
          t_read_lock = 55;
          t_write_lock = 85;
          t_read_unlock = 95;
        end
        1: begin
          t_read_lock = 10;
          t_write_lock = 20;
          t_read_unlock = 70;
        end
        default: begin
          t_read_lock = 25;
          t_write_lock = 50;
          t_read_unlock = 75;
        end
      endcase
      for (int n = 0; n < burst_len; n++) begin
        picked = $urandom_range(0, 99);
        if (picked < t_read_lock) op = OP_READ_LOCK;
        else if (picked < t_write_lock) op = OP_WRITE_LOCK;
        else if (picked < t_read_unlock) op = OP_READ_UNLOCK;
        else op = OP_WRITE_UNLOCK;
        send_request(op, 8'($urandom_range(0, 255)));
        sent_random++;
        if (sent_random == RANDOM_ITEMS / 2) wait_all_results();
      end
    end
    calm = 1'b0;

    wait_all_results();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Covered %0d lock requests and %0d result transactions under random stalls,",
             requests, results);
    $display("with a full wait queue, bad unlocks and queued wakeups of readers and writers.");
    if (mismatches == 0 && outstanding == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
